>>> rtl/core/aw_pkg.sv
// ----------------------------------------------------------------------------
// aw_pkg - shared types and constants for the affine warp block
// Widths of the datapath, configuration register codes and the structs
// passed between the sequencer, the MAC unit and the pixel store.
// ----------------------------------------------------------------------------
package aw_pkg;

    localparam int MaxDimDefault = 256;
    localparam int PixBits       = 16;
    localparam int StoreAw       = 16;
    localparam int StoreDepth    = 1 << StoreAw;
    localparam int DimW          = 9;
    localparam int CntW          = 8;
    localparam int CoefW         = 32;
    localparam int FracW         = 16;
    localparam int PosW          = DimW + FracW;
    localparam int MulAW         = 33;
    localparam int MulBW         = 18;
    localparam int AccW          = 50;
    localparam int CfgIdxW       = 3;
    localparam int CfgDataW      = 64;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_OUT_WIDTH   = 3'd2,
        CFG_OUT_HEIGHT  = 3'd3,
        CFG_ROW0_LINEAR = 3'd4,
        CFG_ROW1_LINEAR = 3'd5,
        CFG_TRANSLATION = 3'd6
    } t_cfg_idx;

    // effective sizes and unpacked matrix terms
    typedef struct packed {
        logic [DimW-1:0]         sw;
        logic [DimW-1:0]         sh;
        logic [DimW-1:0]         ow;
        logic [DimW-1:0]         oh;
        logic signed [CoefW-1:0] a;
        logic signed [CoefW-1:0] b;
        logic signed [CoefW-1:0] c;
        logic signed [CoefW-1:0] d;
        logic signed [CoefW-1:0] tx;
        logic signed [CoefW-1:0] ty;
    } t_cfg;

    typedef struct packed {
        logic                    en;
        logic                    clr;
        logic signed [AccW-1:0]  init;
        logic signed [MulAW-1:0] a;
        logic signed [MulBW-1:0] b;
    } t_mac_op;

    typedef struct packed {
        logic               we;
        logic [StoreAw-1:0] addr;
        logic [PixBits-1:0] wdata;
    } t_store_req;

endpackage

>>> rtl/core/aw_mac.sv
// ----------------------------------------------------------------------------
// aw_mac - shared multiply-accumulate unit
// Signed 33x18 multiplier feeding a 50-bit accumulator. Used for the
// coordinate transform, the row base address and the bilinear blend.
// ----------------------------------------------------------------------------
module aw_mac (
    input  logic                              i_clk,
    input  aw_pkg::t_mac_op                   i_op,
    output logic signed [aw_pkg::AccW-1:0]    o_acc
);

    logic signed [aw_pkg::MulAW+aw_pkg::MulBW-1:0] w_full;
    logic signed [aw_pkg::AccW-1:0]                w_prod;
    logic signed [aw_pkg::AccW-1:0]                r_acc;
    logic signed [aw_pkg::AccW-1:0]                n_acc;

    always_comb begin
        w_full = i_op.a * i_op.b;
        w_prod = w_full[aw_pkg::AccW-1:0];
        n_acc  = (i_op.clr ? i_op.init : r_acc) + w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

>>> rtl/core/aw_store.sv
// ----------------------------------------------------------------------------
// aw_store - single-port source pixel store
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module aw_store (
    input  logic                        i_clk,
    input  aw_pkg::t_store_req          i_req,
    output logic [aw_pkg::PixBits-1:0]  o_rdata
);

    logic [aw_pkg::PixBits-1:0] r_mem [0:aw_pkg::StoreDepth-1];
    logic [aw_pkg::PixBits-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/aw_ctrl.sv
// ----------------------------------------------------------------------------
// aw_ctrl - sequencer for loads and output samples
// Loads write the store when accepted. A sample steps the shared MAC through
// the transform, clamp, four neighbour reads and the vertical blend.
// ----------------------------------------------------------------------------
module aw_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  aw_pkg::t_cfg                      i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_in_opcode,
    input  logic [15:0]                       i_in_pixel,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [15:0]                       o_pixel_out,
    output logic [7:0]                        o_out_x,
    output logic [7:0]                        o_out_y,
    output logic                              o_frame_last,
    output aw_pkg::t_mac_op                   o_mac,
    input  logic signed [aw_pkg::AccW-1:0]    i_acc,
    output aw_pkg::t_store_req                o_store,
    input  logic [aw_pkg::PixBits-1:0]        i_rdata
);

    typedef enum logic [3:0] {
        S_IDLE, S_PX0, S_PX1, S_PY0, S_PY1, S_CLY, S_ROW,
        S_RD00, S_RD10, S_RD01, S_RD11, S_BOT, S_VX0, S_VX1, S_DONE
    } t_state;

    localparam int AW = aw_pkg::StoreAw;
    localparam int DW = aw_pkg::DimW;
    localparam int FW = aw_pkg::FracW;

    t_state                     r_state;
    logic [aw_pkg::CntW-1:0]    r_col;
    logic [aw_pkg::CntW-1:0]    r_row;
    logic [AW-1:0]              r_load_addr;
    logic [DW-1:0]              r_x0, r_x1, r_y0;
    logic                       r_dy;
    logic [FW-1:0]              r_fx, r_fy;
    logic [AW-1:0]              r_base0, r_base1;
    logic [31:0]                r_top, r_bot;
    logic                       r_out_valid;
    logic [15:0]                r_pixel_out;
    logic [7:0]                 r_out_x, r_out_y;
    logic                       r_frame_last;

    logic                       w_in_accept;
    logic                       w_space;
    logic [aw_pkg::PosW-1:0]    w_cx, w_cy;
    logic [FW:0]                w_wx0, w_wy0;
    logic [2*DW-1:0]            w_area;
    logic [AW:0]                w_ld_inc;
    logic [AW-1:0]              w_ld_next;
    logic                       w_row_end, w_frame_end;
    logic [31:0]                w_round;
    logic [AW-1:0]              w_base1;

    // clamp a signed Q34.16 position to [0, (dim-1) << 16]
    function automatic logic [aw_pkg::PosW-1:0] clamp_pos(
        input logic signed [aw_pkg::AccW-1:0] v,
        input logic [DW-1:0]                  dim
    );
        logic [aw_pkg::PosW-1:0] lim;
        logic [aw_pkg::AccW-1:0] lim_ext;
        lim     = {dim - DW'(1), {FW{1'b0}}};
        lim_ext = aw_pkg::AccW'(lim);
        if (v[aw_pkg::AccW-1]) begin
            clamp_pos = '0;
        end else if ($unsigned(v) > lim_ext) begin
            clamp_pos = lim;
        end else begin
            clamp_pos = v[aw_pkg::PosW-1:0];
        end
    endfunction

    function automatic logic signed [aw_pkg::MulAW-1:0] coef_a(
        input logic signed [aw_pkg::CoefW-1:0] c
    );
        coef_a = {c[aw_pkg::CoefW-1], c};
    endfunction

    function automatic logic signed [aw_pkg::AccW-1:0] coef_init(
        input logic signed [aw_pkg::CoefW-1:0] c
    );
        coef_init = {{(aw_pkg::AccW-aw_pkg::CoefW){c[aw_pkg::CoefW-1]}}, c};
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_space     = !r_out_valid || !i_out_stall;

    always_comb begin
        w_cx  = clamp_pos(i_acc, i_cfg.sw);
        w_cy  = clamp_pos(i_acc, i_cfg.sh);
        w_wx0 = 17'h10000 - {1'b0, r_fx};
        w_wy0 = 17'h10000 - {1'b0, r_fy};

        w_area    = i_cfg.sw * i_cfg.sh;
        w_ld_inc  = {1'b0, r_load_addr} + (AW+1)'(1);
        w_ld_next = ((2*DW)'(w_ld_inc) >= w_area) ? '0 : w_ld_inc[AW-1:0];

        w_row_end   = ({1'b0, r_col} + DW'(1)) >= i_cfg.ow;
        w_frame_end = w_row_end && (({1'b0, r_row} + DW'(1)) >= i_cfg.oh);

        // total = acc >> 16, then round half up to 16 bits
        w_round = i_acc[47:16] + 32'h0000_8000;
        w_base1 = i_acc[AW-1:0] + (r_dy ? AW'(i_cfg.sw) : '0);
    end

    // MAC operand select
    always_comb begin
        o_mac      = '0;
        o_mac.init = '0;
        case (r_state)
            S_PX0: begin
                o_mac.en   = 1'b1;
                o_mac.clr  = 1'b1;
                o_mac.init = coef_init(i_cfg.tx);
                o_mac.a    = coef_a(i_cfg.a);
                o_mac.b    = aw_pkg::MulBW'(r_col);
            end
            S_PX1: begin
                o_mac.en = 1'b1;
                o_mac.a  = coef_a(i_cfg.b);
                o_mac.b  = aw_pkg::MulBW'(r_row);
            end
            S_PY0: begin
                o_mac.en   = 1'b1;
                o_mac.clr  = 1'b1;
                o_mac.init = coef_init(i_cfg.ty);
                o_mac.a    = coef_a(i_cfg.c);
                o_mac.b    = aw_pkg::MulBW'(r_col);
            end
            S_PY1: begin
                o_mac.en = 1'b1;
                o_mac.a  = coef_a(i_cfg.d);
                o_mac.b  = aw_pkg::MulBW'(r_row);
            end
            S_ROW: begin
                o_mac.en  = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = aw_pkg::MulAW'(r_y0);
                o_mac.b   = aw_pkg::MulBW'(i_cfg.sw);
            end
            S_RD10: begin
                o_mac.en  = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = aw_pkg::MulAW'(i_rdata);
                o_mac.b   = aw_pkg::MulBW'(w_wx0);
            end
            S_RD01: begin
                o_mac.en = 1'b1;
                o_mac.a  = aw_pkg::MulAW'(i_rdata);
                o_mac.b  = aw_pkg::MulBW'(r_fx);
            end
            S_RD11: begin
                o_mac.en  = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = aw_pkg::MulAW'(i_rdata);
                o_mac.b   = aw_pkg::MulBW'(w_wx0);
            end
            S_BOT: begin
                o_mac.en = 1'b1;
                o_mac.a  = aw_pkg::MulAW'(i_rdata);
                o_mac.b  = aw_pkg::MulBW'(r_fx);
            end
            S_VX0: begin
                o_mac.en  = 1'b1;
                o_mac.clr = 1'b1;
                o_mac.a   = aw_pkg::MulAW'(r_top);
                o_mac.b   = aw_pkg::MulBW'(w_wy0);
            end
            S_VX1: begin
                o_mac.en = 1'b1;
                o_mac.a  = aw_pkg::MulAW'(i_acc[31:0]);
                o_mac.b  = aw_pkg::MulBW'(r_fy);
            end
            default: begin
                o_mac.en = 1'b0;
            end
        endcase
        // the bottom row sum is parked in r_bot before S_VX0 overwrites acc
        if (r_state == S_VX1) begin
            o_mac.a = aw_pkg::MulAW'(r_bot);
        end
    end

    // store port select
    always_comb begin
        o_store.we    = 1'b0;
        o_store.addr  = r_load_addr;
        o_store.wdata = i_in_pixel;
        case (r_state)
            S_IDLE: begin
                o_store.we = w_in_accept && !i_in_opcode;
            end
            S_RD00:  o_store.addr = i_acc[AW-1:0] + AW'(r_x0);
            S_RD10:  o_store.addr = r_base0 + AW'(r_x1);
            S_RD01:  o_store.addr = r_base1 + AW'(r_x0);
            S_RD11:  o_store.addr = r_base1 + AW'(r_x1);
            default: o_store.addr = r_load_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_load_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE sets the output register itself
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        if (i_in_opcode) begin
                            r_state <= S_PX0;
                        end else begin
                            r_load_addr <= w_ld_next;
                        end
                    end
                end
                S_PX0: r_state <= S_PX1;
                S_PX1: r_state <= S_PY0;
                S_PY0: begin
                    r_x0    <= w_cx[aw_pkg::PosW-1:FW];
                    r_fx    <= w_cx[FW-1:0];
                    r_x1    <= (w_cx[aw_pkg::PosW-1:FW] == i_cfg.sw - DW'(1)) ?
                               w_cx[aw_pkg::PosW-1:FW] :
                               w_cx[aw_pkg::PosW-1:FW] + DW'(1);
                    r_state <= S_PY1;
                end
                S_PY1: r_state <= S_CLY;
                S_CLY: begin
                    r_y0    <= w_cy[aw_pkg::PosW-1:FW];
                    r_fy    <= w_cy[FW-1:0];
                    r_dy    <= (w_cy[aw_pkg::PosW-1:FW] != i_cfg.sh - DW'(1));
                    r_state <= S_ROW;
                end
                S_ROW: r_state <= S_RD00;
                S_RD00: begin
                    r_base0 <= i_acc[AW-1:0];
                    r_base1 <= w_base1;
                    r_state <= S_RD10;
                end
                S_RD10: r_state <= S_RD01;
                S_RD01: r_state <= S_RD11;
                S_RD11: begin
                    r_top   <= i_acc[31:0];
                    r_state <= S_BOT;
                end
                S_BOT: r_state <= S_VX0;
                S_VX0: begin
                    r_bot   <= i_acc[31:0];
                    r_state <= S_VX1;
                end
                S_VX1: r_state <= S_DONE;
                S_DONE: begin
                    if (w_space) begin
                        r_out_valid  <= 1'b1;
                        r_pixel_out  <= w_round[31:16];
                        r_out_x      <= r_col;
                        r_out_y      <= r_row;
                        r_frame_last <= w_frame_end;
                        if (w_row_end) begin
                            r_col <= '0;
                            r_row <= w_frame_end ? '0 : r_row + 8'd1;
                        end else begin
                            r_col <= r_col + 8'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pixel_out;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_frame_last = r_frame_last;

`ifndef SYNTH
    a_sample_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_in_opcode) |=> o_in_stall)
        else $error("sample beat did not stall the input");

    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_store.we |-> (r_state == S_IDLE))
        else $error("store write outside idle");

    a_neighbour_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD00) |-> (r_x0 < i_cfg.sw && r_y0 < i_cfg.sh &&
                                 r_x1 < i_cfg.sw))
        else $error("clamped neighbour outside source");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_space && w_frame_end) |=> (r_col == '0 && r_row == '0))
        else $error("raster counters did not wrap at frame end");
`endif

endmodule

>>> rtl/core/affine_warp_bilinear.sv
// ----------------------------------------------------------------------------
// affine_warp_bilinear - affine image warp with bilinear sampling
// Source pixels are loaded in raster order; each sample beat yields one
// output pixel from a 2x3 Q16.16 map, clamped to the source edges.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): opcode 0 writes i_in_pixel to
//   the next source location, opcode 1 requests the next output pixel.
//   Output channel (o_out_valid / i_out_stall): one beat per sample, with
//   column, row and a flag on the last pixel of the frame.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): write while
//   the block is idle; index 7 is ignored.
//   Load beats do not stall the input. A sample beat keeps o_in_stall high
//   until its result is registered on the output, so the block takes no
//   new beat before the sample is through. This is set by the shared
//   multiply-accumulate unit (transform, row base, blend) and the four
//   reads of the single-port source store.
//   The output register holds one result; a stalled receiver delays only
//   the end of the next sample, loads are still taken.
//   Reset (synchronous, active low) returns the config registers to their
//   defaults, clears state, output valid, load address, raster counters;
//   the store is not cleared and must be loaded before it is sampled.
// ----------------------------------------------------------------------------
module affine_warp_bilinear #(
    parameter int MAX_DIM = aw_pkg::MaxDimDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_in_opcode,
    input  logic [15:0]                   i_in_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [15:0]                   o_pixel_out,
    output logic [7:0]                    o_out_x,
    output logic [7:0]                    o_out_y,
    output logic                          o_frame_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [aw_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [aw_pkg::CfgDataW-1:0]   i_cfg_data
);

    localparam int DW     = aw_pkg::DimW;
    localparam int DimCap = (MAX_DIM < (1 << DW) - 1) ? MAX_DIM : (1 << DW) - 1;
    localparam logic [DW-1:0] DimCapV = DW'(DimCap);

    logic [DW-1:0]                 r_src_w, r_src_h, r_out_w, r_out_h;
    logic [aw_pkg::CfgDataW-1:0]   r_row0, r_row1, r_trans;
    aw_pkg::t_cfg                  w_cfg;
    aw_pkg::t_mac_op               w_mac;
    aw_pkg::t_store_req            w_store;
    logic signed [aw_pkg::AccW-1:0] w_acc;
    logic [aw_pkg::PixBits-1:0]    w_rdata;

    function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
        if (v == '0) begin
            eff_dim = DW'(1);
        end else if (v > DimCapV) begin
            eff_dim = DimCapV;
        end else begin
            eff_dim = v;
        end
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 9'd256;
            r_src_h <= 9'd256;
            r_out_w <= 9'd256;
            r_out_h <= 9'd256;
            r_row0  <= 64'h0001_0000_0000_0000;
            r_row1  <= 64'h0000_0000_0001_0000;
            r_trans <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                aw_pkg::CFG_SRC_WIDTH:   r_src_w <= i_cfg_data[DW-1:0];
                aw_pkg::CFG_SRC_HEIGHT:  r_src_h <= i_cfg_data[DW-1:0];
                aw_pkg::CFG_OUT_WIDTH:   r_out_w <= i_cfg_data[DW-1:0];
                aw_pkg::CFG_OUT_HEIGHT:  r_out_h <= i_cfg_data[DW-1:0];
                aw_pkg::CFG_ROW0_LINEAR: r_row0  <= i_cfg_data;
                aw_pkg::CFG_ROW1_LINEAR: r_row1  <= i_cfg_data;
                aw_pkg::CFG_TRANSLATION: r_trans <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cfg.sw = eff_dim(r_src_w);
        w_cfg.sh = eff_dim(r_src_h);
        w_cfg.ow = eff_dim(r_out_w);
        w_cfg.oh = eff_dim(r_out_h);
        w_cfg.a  = r_row0[63:32];
        w_cfg.b  = r_row0[31:0];
        w_cfg.c  = r_row1[63:32];
        w_cfg.d  = r_row1[31:0];
        w_cfg.tx = r_trans[63:32];
        w_cfg.ty = r_trans[31:0];
    end

    aw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_opcode  (i_in_opcode),
        .i_in_pixel   (i_in_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_frame_last (o_frame_last),
        .o_mac        (w_mac),
        .i_acc        (w_acc),
        .o_store      (w_store),
        .i_rdata      (w_rdata)
    );

    aw_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_mac),
        .o_acc (w_acc)
    );

    aw_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_store),
        .o_rdata (w_rdata)
    );

endmodule

>>> verif/affine_warp_bilinear_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_warp_bilinear_test - self-checking bench for the affine warp block
// Loads small source images, sweeps the size, matrix and offset registers
// and checks every output beat against a bit-exact bilinear predictor.
// Random gaps on both channels, one long output hold-off and pauses in
// between runs.
// ----------------------------------------------------------------------------
module affine_warp_bilinear_test;

    localparam int          MaxDim       = aw_pkg::MaxDimDefault;
    localparam int          OneQ16       = 65536;
    localparam int          ItemTarget   = 760;
    localparam int          HoldCycles   = 400;
    localparam int          SettleCycles = 30;
    localparam int          CycleLimit   = 1000000;
    // index the block decodes to nothing
    localparam logic [2:0]  CfgIdxSpare  = 3'd7;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_warp_op;

    typedef struct packed {
        logic [15:0] pix;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        frame_end;
    } t_warp_pixel;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic                        i_in_opcode  = 1'b0;
    logic [15:0]                 i_in_pixel   = '0;
    logic                        i_out_stall  = 1'b0;
    logic                        i_cfg_valid  = 1'b0;
    logic [aw_pkg::CfgIdxW-1:0]  i_cfg_index  = '0;
    logic [aw_pkg::CfgDataW-1:0] i_cfg_data   = '0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [15:0]                 o_pixel_out;
    logic [7:0]                  o_out_x;
    logic [7:0]                  o_out_y;
    logic                        o_frame_last;
    logic                        o_cfg_ready;

    // predictor state
    bit   [15:0]  src_mem     [0:65535];
    bit           src_written [0:65535];
    bit   [15:0]  load_addr   = '0;
    bit   [7:0]   col_cnt     = '0;
    bit   [7:0]   row_cnt     = '0;
    bit   [8:0]   cfg_src_w   = 9'd256;
    bit   [8:0]   cfg_src_h   = 9'd256;
    bit   [8:0]   cfg_out_w   = 9'd256;
    bit   [8:0]   cfg_out_h   = 9'd256;
    bit   [63:0]  cfg_row0    = 64'h0001_0000_0000_0000;
    bit   [63:0]  cfg_row1    = 64'h0000_0000_0001_0000;
    bit   [63:0]  cfg_trans   = '0;

    t_warp_pixel  expected_pixels [$];
    int           mismatch_count = 0;
    int           beats_sent     = 0;
    int unsigned  cycle_count    = 0;
    bit           quiet          = 1'b0;
    bit           hold_req       = 1'b0;

    affine_warp_bilinear dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_opcode  (i_in_opcode),
        .i_in_pixel   (i_in_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint eff_dim(bit [8:0] v);
        if (v == 0) return 1;
        if (v > MaxDim) return MaxDim;
        return longint'(v);
    endfunction

    function automatic longint unsigned src_pixel(longint x, longint y, longint w);
        bit [15:0] addr;
        addr = 16'(y * w + x);
        return longint'(src_mem[addr]);
    endfunction

    function automatic void store_pixel(bit [15:0] pix);
        longint n;
        n = eff_dim(cfg_src_w) * eff_dim(cfg_src_h);
        src_mem[load_addr]     = pix;
        src_written[load_addr] = 1'b1;
        if (longint'(load_addr) + 1 >= n) load_addr = '0;
        else load_addr = load_addr + 16'd1;
    endfunction

    function automatic t_warp_pixel warp_sample();
        longint sw, sh, ow, oh, cx, cy, px, py, x0, y0, x1, y1;
        longint unsigned fx, fy, top, bot, total;
        int a, b, c, d, tx, ty;
        bit row_end;
        t_warp_pixel r;
        sw = eff_dim(cfg_src_w);
        sh = eff_dim(cfg_src_h);
        ow = eff_dim(cfg_out_w);
        oh = eff_dim(cfg_out_h);
        a  = cfg_row0[63:32];
        b  = cfg_row0[31:0];
        c  = cfg_row1[63:32];
        d  = cfg_row1[31:0];
        tx = cfg_trans[63:32];
        ty = cfg_trans[31:0];
        cx = longint'(col_cnt);
        cy = longint'(row_cnt);
        px = longint'(a) * cx + longint'(b) * cy + longint'(tx);
        py = longint'(c) * cx + longint'(d) * cy + longint'(ty);
        if (px < 0) px = 0;
        if (px > (sw - 1) * OneQ16) px = (sw - 1) * OneQ16;
        if (py < 0) py = 0;
        if (py > (sh - 1) * OneQ16) py = (sh - 1) * OneQ16;
        x0 = px / OneQ16;
        y0 = py / OneQ16;
        fx = longint'(px % OneQ16);
        fy = longint'(py % OneQ16);
        x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
        y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
        top = src_pixel(x0, y0, sw) * (OneQ16 - fx) + src_pixel(x1, y0, sw) * fx;
        bot = src_pixel(x0, y1, sw) * (OneQ16 - fx) + src_pixel(x1, y1, sw) * fx;
        total = (top >> 16) * (OneQ16 - fy) + (bot >> 16) * fy;
        // low halves of the row blends still carry weight
        total += ((top & 64'hFFFF) * (OneQ16 - fy) + (bot & 64'hFFFF) * fy) >> 16;
        r.pix = 16'((total + 64'h8000) >> 16);
        r.col = col_cnt;
        r.row = row_cnt;
        row_end = (cx + 1 >= ow);
        r.frame_end = row_end && (cy + 1 >= oh);
        if (row_end) begin
            col_cnt = '0;
            row_cnt = r.frame_end ? 8'd0 : row_cnt + 8'd1;
        end else begin
            col_cnt = col_cnt + 8'd1;
        end
        return r;
    endfunction

    // every store entry of the current source image has been loaded
    function automatic bit source_loaded();
        longint n;
        n = eff_dim(cfg_src_w) * eff_dim(cfg_src_h);
        for (longint i = 0; i < n; i++) begin
            if (!src_written[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic bit [15:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic bit [8:0] pick_dim();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 9'd256;
            2:       return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(1, 16));
        endcase
    endfunction

    // signed Q16.16, mostly within +-2.0
    function automatic bit [31:0] pick_coef();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return '0;
            2:       return 32'h0001_0000;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic bit [31:0] pick_offset(longint dim);
        if ($urandom_range(0, 7) == 0) return $urandom();
        return $urandom_range(0, 32'((dim + 2) * OneQ16)) - 32'h0001_0000;
    endfunction

    // ------------------------------------------------------------------
    // channel tasks
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic write_reg(logic [aw_pkg::CfgIdxW-1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            aw_pkg::CFG_SRC_WIDTH:   cfg_src_w = val[8:0];
            aw_pkg::CFG_SRC_HEIGHT:  cfg_src_h = val[8:0];
            aw_pkg::CFG_OUT_WIDTH:   cfg_out_w = val[8:0];
            aw_pkg::CFG_OUT_HEIGHT:  cfg_out_h = val[8:0];
            aw_pkg::CFG_ROW0_LINEAR: cfg_row0  = val;
            aw_pkg::CFG_ROW1_LINEAR: cfg_row1  = val;
            aw_pkg::CFG_TRANSLATION: cfg_trans = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays high on return unless a gap follows
    task automatic send_beat(t_warp_op op, bit [15:0] pix);
        int gap;
        i_in_valid  <= 1'b1;
        i_in_opcode <= op;
        i_in_pixel  <= pix;
        do @(posedge i_clk); while (o_in_stall);
        if (op == OP_LOAD) store_pixel(pix);
        else expected_pixels.push_back(warp_sample());
        beats_sent++;
        if (!quiet) begin
            gap = pick_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic load_image();
        while (!source_loaded()) send_beat(OP_LOAD, rand_pixel());
    endtask

    // receiver: random stall bursts, or one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_warp_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("output beat with nothing pending", '0, '0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_out !== want.pix)
                    report_mismatch("pixel_out", o_pixel_out, want.pix);
                if (o_out_x !== want.col)
                    report_mismatch("out_x", o_out_x, want.col);
                if (o_out_y !== want.row)
                    report_mismatch("out_y", o_out_y, want.row);
                if (o_frame_last !== want.frame_end)
                    report_mismatch("frame_last", o_frame_last, want.frame_end);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // identity map and 256x256 output frame straight out of reset
    task automatic test_reset_defaults();
        write_reg(aw_pkg::CFG_SRC_WIDTH, 64'd2);
        write_reg(aw_pkg::CFG_SRC_HEIGHT, 64'd2);
        send_beat(OP_LOAD, 16'h0000);
        send_beat(OP_LOAD, 16'hFFFF);
        send_beat(OP_LOAD, 16'h8001);
        send_beat(OP_LOAD, 16'h7FFE);
        // third column lies past the right edge
        repeat (3) send_beat(OP_SAMPLE, rand_pixel());
        drain();
    endtask

    // fractional scale and offset: clamps on both sides, edge neighbours;
    // the column counter enters already past the narrowed width
    task automatic test_clamp_and_blend();
        write_reg(aw_pkg::CFG_OUT_WIDTH, 64'd3);
        write_reg(aw_pkg::CFG_OUT_HEIGHT, 64'd2);
        write_reg(aw_pkg::CFG_ROW0_LINEAR, 64'h0000_C000_0000_0000);
        write_reg(aw_pkg::CFG_ROW1_LINEAR, 64'h0000_0000_0001_8000);
        write_reg(aw_pkg::CFG_TRANSLATION, 64'hFFFF_8000_0000_4000);
        repeat (4) send_beat(OP_SAMPLE, rand_pixel());
        drain();
    endtask

    // row counter past a shrunken height ends the frame
    task automatic test_counter_shrink();
        write_reg(aw_pkg::CFG_OUT_WIDTH, 64'd2);
        write_reg(aw_pkg::CFG_OUT_HEIGHT, 64'd4);
        repeat (5) send_beat(OP_SAMPLE, rand_pixel());
        drain();
        write_reg(aw_pkg::CFG_OUT_HEIGHT, 64'd1);
        send_beat(OP_SAMPLE, rand_pixel());
        drain();
    endtask

    // zero sizes act as one; extreme coefficients all clamp away
    task automatic test_degenerate_sizes();
        write_reg(aw_pkg::CFG_SRC_WIDTH, 64'd0);
        write_reg(aw_pkg::CFG_SRC_HEIGHT, 64'd0);
        write_reg(aw_pkg::CFG_OUT_WIDTH, 64'd0);
        write_reg(aw_pkg::CFG_OUT_HEIGHT, 64'd0);
        write_reg(aw_pkg::CFG_ROW0_LINEAR, 64'h7FFF_FFFF_8000_0000);
        write_reg(aw_pkg::CFG_ROW1_LINEAR, 64'h8000_0000_7FFF_FFFF);
        write_reg(aw_pkg::CFG_TRANSLATION, 64'h8000_0000_7FFF_FFFF);
        write_reg(CfgIdxSpare, {$urandom(), $urandom()});
        send_beat(OP_LOAD, 16'hFFFF);
        repeat (2) send_beat(OP_SAMPLE, rand_pixel());
        drain();
    endtask

    task automatic test_random_warps();
        bit [8:0] sw, sh;
        int run_len;
        while (beats_sent < ItemTarget) begin
            sw = pick_dim();
            sh = pick_dim();
            // keep each source image to a few hundred loads
            if (eff_dim(sw) * eff_dim(sh) > 512) begin
                if ($urandom_range(0, 1)) sh = 9'($urandom_range(0, 2));
                else sw = 9'($urandom_range(0, 2));
            end
            write_reg(aw_pkg::CFG_SRC_WIDTH, 64'(sw));
            write_reg(aw_pkg::CFG_SRC_HEIGHT, 64'(sh));
            write_reg(aw_pkg::CFG_OUT_WIDTH, 64'(pick_dim()));
            write_reg(aw_pkg::CFG_OUT_HEIGHT, 64'(pick_dim()));
            write_reg(aw_pkg::CFG_ROW0_LINEAR, {pick_coef(), pick_coef()});
            write_reg(aw_pkg::CFG_ROW1_LINEAR, {pick_coef(), pick_coef()});
            write_reg(aw_pkg::CFG_TRANSLATION,
                      {pick_offset(eff_dim(sw)), pick_offset(eff_dim(sh))});
            quiet = ($urandom_range(0, 4) == 0);
            load_image();
            run_len = $urandom_range(30, 110);
            repeat (run_len) begin
                if ($urandom_range(0, 7) == 0) send_beat(OP_LOAD, rand_pixel());
                else send_beat(OP_SAMPLE, rand_pixel());
            end
            quiet = 1'b0;
            drain();
        end
    endtask

    // receiver holds off while samples keep coming, so the input backs up
    task automatic test_output_holdoff();
        load_image();
        quiet    = 1'b1;
        hold_req = 1'b1;
        repeat (24) send_beat(OP_SAMPLE, rand_pixel());
        quiet = 1'b0;
        drain();
        while (hold_req) @(posedge i_clk);
    endtask

    // short bursts, each waited out completely before the next
    task automatic test_sender_pause();
        load_image();
        repeat (3) begin
            repeat ($urandom_range(4, 12)) send_beat(OP_SAMPLE, rand_pixel());
            drain();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_clamp_and_blend();
        test_counter_shrink();
        test_degenerate_sizes();
        test_random_warps();
        test_output_holdoff();
        test_sender_pause();
        drain();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
